// ----- rtl/i8c_pkg.sv -----
// i8c_pkg: shared constants, codes and types for the int8 conv2d requantize block.
// No dependencies.
`default_nettype none
package i8c_pkg;

  localparam int DEF_MAX_IMAGE        = 32;
  localparam int DEF_MAX_IN_CHANNELS  = 8;
  localparam int DEF_MAX_OUT_CHANNELS = 16;
  localparam int DEF_MAX_KERNEL       = 5;

  localparam logic [1:0] ACT_PIXEL   = 2'd0;
  localparam logic [1:0] ACT_WEIGHT  = 2'd1;
  localparam logic [1:0] ACT_PARAM   = 2'd2;
  localparam logic [1:0] ACT_COMPUTE = 2'd3;

  localparam logic [2:0] REG_IN_CH  = 3'd0;
  localparam logic [2:0] REG_OUT_CH = 3'd1;
  localparam logic [2:0] REG_IMAGE  = 3'd2;
  localparam logic [2:0] REG_KERNEL = 3'd3;
  localparam logic [2:0] REG_IN_ZP  = 3'd4;
  localparam logic [2:0] REG_OUT_ZP = 3'd5;

  localparam int PARAM_W = 16 + 32 + 5;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/i8c_ram.sv -----
// i8c_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module i8c_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                we_i,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr_i,
  input  wire logic [W-1:0]                        wdata_i,
  input  wire logic                                re_i,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr_i,
  output logic      [W-1:0]                        rdata_o
);
  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/i8c_mac.sv -----
// i8c_mac: multiply-accumulate pipeline, weight times (pixel - zero point).
// Depends on i8c_pkg.
`default_nettype none
module i8c_mac
  import i8c_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mac_ctl_t           ctl_i,
  input  wire logic signed [7:0]  pixel_i,
  input  wire logic signed [7:0]  weight_i,
  input  wire logic signed [7:0]  in_zp_i,
  output logic                    done_o,
  output logic [31:0]             acc_o
);
  mac_ctl_t           ctl_q;
  logic signed [16:0] prod_q;
  logic signed [8:0]  diff;
  logic [31:0]        acc_d;

  assign diff = 9'(pixel_i) - 9'(in_zp_i);
  assign acc_d = ctl_q.first ? 32'($signed(prod_q)) : acc_o + 32'($signed(prod_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= '0;
      done_o <= 1'b0;
    end else begin
      ctl_q  <= ctl_i;
      done_o <= ctl_q.valid && ctl_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 17'(weight_i * diff);
    if (ctl_q.valid) begin
      acc_o <= acc_d;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/i8c_requant.sv -----
// i8c_requant: bias add, rounded doubling high product, rounding shift,
// output zero point and int8 saturation, four pipeline stages. Depends on i8c_pkg.
`default_nettype none
module i8c_requant
  import i8c_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic [31:0]        acc_i,
  input  wire logic signed [15:0] bias_i,
  input  wire logic signed [31:0] mult_i,
  input  wire logic [4:0]         shift_i,
  input  wire logic signed [7:0]  out_zp_i,
  output logic                    valid_o,
  output logic signed [7:0]       act_o
);
  logic [3:0]         v_q;
  logic signed [31:0] sum_q;
  logic signed [63:0] prod_q;
  logic               sat_q;
  logic signed [31:0] hp_q;
  logic signed [63:0] rnd;
  logic signed [63:0] quo;
  logic signed [31:0] hp_d;
  logic signed [31:0] shq;
  logic [31:0]        mask;
  logic [31:0]        rem;
  logic [31:0]        thr;
  logic signed [32:0] res;

  always_comb begin
    rnd  = prod_q + ((prod_q >= 0) ? 64'sd1073741824 : -64'sd1073741823);
    quo  = (rnd < 0) ? ((rnd + 64'sd2147483647) >>> 31) : (rnd >>> 31);
    hp_d = sat_q ? 32'sh7fffffff : quo[31:0];
    shq  = hp_q >>> shift_i;
    mask = (32'd1 << shift_i) - 32'd1;
    rem  = hp_q & mask;
    thr  = (mask >> 1) + {31'd0, hp_q[31]};
    res  = 33'(shq) + ((rem > thr) ? 33'sd1 : 33'sd0) + 33'(out_zp_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= acc_i + 32'(bias_i);
    prod_q <= sum_q * mult_i;
    sat_q  <= (sum_q == 32'sh80000000) && (mult_i == 32'sh80000000);
    hp_q   <= hp_d;
    if (res < -33'sd128) begin
      act_o <= -8'sd128;
    end else if (res > 33'sd127) begin
      act_o <= 8'sd127;
    end else begin
      act_o <= res[7:0];
    end
  end

  assign valid_o = v_q[3];
endmodule
`default_nettype wire

// ----- rtl/int8_conv2d_requantize.sv -----
// int8_conv2d_requantize: quantized int8 valid 2D convolution with requantization.
// Depends on i8c_pkg, i8c_ram, i8c_mac, i8c_requant.
//
//  channel | handshake               | payload
//  in      | in_valid_i / in_ready_o | action, row, col, channels, kernel pos, values
//  out     | out_valid_o/out_ready_i | out_row, out_col, out_chan, activation, last
//  cfg     | cfg_we_i                | cfg_addr_i, cfg_wdata_i
//
// Load items are written to their store as they are taken, and the block stays idle. A compute
// item runs, per output channel, through K*K*input_channels products on the single MAC (K the
// kernel side), then through the MAC and requantize pipeline until the result shows, then waits for it to be taken.
// One item at a time; new items are taken only when idle.
// Stores need no clearing after reset.
`default_nettype none
module int8_conv2d_requantize
  import i8c_pkg::*;
#(
  parameter int MAX_IMAGE        = DEF_MAX_IMAGE,
  parameter int MAX_IN_CHANNELS  = DEF_MAX_IN_CHANNELS,
  parameter int MAX_OUT_CHANNELS = DEF_MAX_OUT_CHANNELS,
  parameter int MAX_KERNEL       = DEF_MAX_KERNEL
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_addr_i,
  input  wire logic [7:0]         cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         action_i,
  input  wire logic [4:0]         row_i,
  input  wire logic [4:0]         col_i,
  input  wire logic [2:0]         in_channel_i,
  input  wire logic [3:0]         out_channel_i,
  input  wire logic [2:0]         kernel_row_i,
  input  wire logic [2:0]         kernel_col_i,
  input  wire logic signed [7:0]  sample_i,
  input  wire logic signed [15:0] channel_bias_i,
  input  wire logic signed [31:0] multiplier_i,
  input  wire logic [4:0]         right_shift_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [4:0]              out_row_o,
  output logic [4:0]              out_col_o,
  output logic [3:0]              out_chan_o,
  output logic signed [7:0]       activation_o,
  output logic                    last_o
);
  localparam int IMG_D = MAX_IMAGE * MAX_IMAGE * MAX_IN_CHANNELS;
  localparam int WGT_D = MAX_OUT_CHANNELS * MAX_KERNEL * MAX_KERNEL * MAX_IN_CHANNELS;
  localparam int IAW   = (IMG_D > 1) ? $clog2(IMG_D) : 1;
  localparam int WAW   = (WGT_D > 1) ? $clog2(WGT_D) : 1;
  localparam int PAW   = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int ICW   = $clog2(MAX_IN_CHANNELS + 1);
  localparam int OCW   = $clog2(MAX_OUT_CHANNELS + 1);
  localparam int ISW   = $clog2(MAX_IMAGE + 1);
  localparam int KSW   = $clog2(MAX_KERNEL + 1);
  localparam int IS_RST = (MAX_IMAGE < 32) ? MAX_IMAGE : 32;
  localparam int KS_RST = (MAX_KERNEL < 5) ? MAX_KERNEL : 5;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_OUT} state_e;

  state_e            state_q;
  logic [ICW-1:0]    ic_q;
  logic [OCW-1:0]    oc_q;
  logic [ISW-1:0]    is_q;
  logic [KSW-1:0]    ks_q;
  logic signed [7:0] izp_q;
  logic signed [7:0] ozp_q;
  logic [4:0]        row_q;
  logic [4:0]        col_q;
  logic [OCW-1:0]    o_q;
  logic [KSW-1:0]    m_q;
  logic [KSW-1:0]    n_q;
  logic [ICW-1:0]    i_q;

  logic              in_acc;
  logic              in_map;
  int                fm;
  logic              img_we;
  logic              wgt_we;
  logic              par_we;
  logic [IAW-1:0]    img_waddr;
  logic [WAW-1:0]    wgt_waddr;
  logic [IAW-1:0]    img_raddr;
  logic [WAW-1:0]    wgt_raddr;
  logic [7:0]        pix_rd;
  logic [7:0]        wgt_rd;
  logic [PARAM_W-1:0] par_rd;
  logic              first_el;
  logic              last_i;
  logic              last_n;
  logic              last_el;
  mac_ctl_t          issue;
  mac_ctl_t          ctl_q;
  logic              mac_done;
  logic [31:0]       acc;
  logic              rq_valid;
  logic signed [7:0] rq_act;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    fm = int'(is_q) - int'(ks_q) + 1;
    in_map = (int'(ks_q) <= int'(is_q)) && (int'(row_i) < fm) && (int'(col_i) < fm);
  end

  assign img_we = in_acc && (action_i == ACT_PIXEL) && (int'(row_i) < MAX_IMAGE) &&
                  (int'(col_i) < MAX_IMAGE) && (int'(in_channel_i) < MAX_IN_CHANNELS);
  assign wgt_we = in_acc && (action_i == ACT_WEIGHT) &&
                  (int'(out_channel_i) < MAX_OUT_CHANNELS) &&
                  (int'(kernel_row_i) < MAX_KERNEL) && (int'(kernel_col_i) < MAX_KERNEL) &&
                  (int'(in_channel_i) < MAX_IN_CHANNELS);
  assign par_we = in_acc && (action_i == ACT_PARAM) &&
                  (int'(out_channel_i) < MAX_OUT_CHANNELS);

  assign img_waddr = IAW'((int'(row_i) * MAX_IMAGE + int'(col_i)) * MAX_IN_CHANNELS +
                          int'(in_channel_i));
  assign wgt_waddr = WAW'(((int'(out_channel_i) * MAX_KERNEL + int'(kernel_row_i)) *
                           MAX_KERNEL + int'(kernel_col_i)) * MAX_IN_CHANNELS +
                          int'(in_channel_i));
  assign img_raddr = IAW'(((int'(row_q) + int'(m_q)) * MAX_IMAGE + int'(col_q) +
                           int'(n_q)) * MAX_IN_CHANNELS + int'(i_q));
  assign wgt_raddr = WAW'(((int'(o_q) * MAX_KERNEL + int'(m_q)) * MAX_KERNEL +
                           int'(n_q)) * MAX_IN_CHANNELS + int'(i_q));

  assign first_el = (m_q == '0) && (n_q == '0) && (i_q == '0);
  assign last_i   = (i_q == ic_q - 1'b1);
  assign last_n   = (n_q == ks_q - 1'b1);
  assign last_el  = last_i && last_n && (m_q == ks_q - 1'b1);

  always_comb begin
    issue.valid = (state_q == ST_RUN);
    issue.first = first_el;
    issue.last  = last_el;
  end

  i8c_ram #(.W(8), .D(IMG_D)) u_img (
    .clk_i, .we_i(img_we), .waddr_i(img_waddr), .wdata_i(sample_i),
    .re_i(issue.valid), .raddr_i(img_raddr), .rdata_o(pix_rd)
  );

  i8c_ram #(.W(8), .D(WGT_D)) u_wgt (
    .clk_i, .we_i(wgt_we), .waddr_i(wgt_waddr), .wdata_i(sample_i),
    .re_i(issue.valid), .raddr_i(wgt_raddr), .rdata_o(wgt_rd)
  );

  i8c_ram #(.W(PARAM_W), .D(MAX_OUT_CHANNELS)) u_par (
    .clk_i, .we_i(par_we), .waddr_i(PAW'(out_channel_i)),
    .wdata_i({channel_bias_i, multiplier_i, right_shift_i}),
    .re_i(issue.valid && first_el), .raddr_i(PAW'(o_q)), .rdata_o(par_rd)
  );

  i8c_mac u_mac (
    .clk_i, .rst_ni, .ctl_i(ctl_q), .pixel_i(pix_rd), .weight_i(wgt_rd),
    .in_zp_i(izp_q), .done_o(mac_done), .acc_o(acc)
  );

  i8c_requant u_rq (
    .clk_i, .rst_ni, .valid_i(mac_done), .acc_i(acc),
    .bias_i(par_rd[PARAM_W-1 -: 16]), .mult_i(par_rd[36:5]), .shift_i(par_rd[4:0]),
    .out_zp_i(ozp_q), .valid_o(rq_valid), .act_o(rq_act)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q  <= ICW'(1);
      oc_q  <= OCW'(1);
      is_q  <= ISW'(IS_RST);
      ks_q  <= KSW'(KS_RST);
      izp_q <= '0;
      ozp_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_IN_CH: begin
          ic_q <= (cfg_wdata_i[3:0] == '0) ? ICW'(1) :
                  (int'(cfg_wdata_i[3:0]) > MAX_IN_CHANNELS) ? ICW'(MAX_IN_CHANNELS) :
                  ICW'(cfg_wdata_i[3:0]);
        end
        REG_OUT_CH: begin
          oc_q <= (cfg_wdata_i[4:0] == '0) ? OCW'(1) :
                  (int'(cfg_wdata_i[4:0]) > MAX_OUT_CHANNELS) ? OCW'(MAX_OUT_CHANNELS) :
                  OCW'(cfg_wdata_i[4:0]);
        end
        REG_IMAGE: begin
          is_q <= (cfg_wdata_i[5:0] == '0) ? ISW'(1) :
                  (int'(cfg_wdata_i[5:0]) > MAX_IMAGE) ? ISW'(MAX_IMAGE) :
                  ISW'(cfg_wdata_i[5:0]);
        end
        REG_KERNEL: begin
          ks_q <= (cfg_wdata_i[2:0] == '0) ? KSW'(1) :
                  (int'(cfg_wdata_i[2:0]) > MAX_KERNEL) ? KSW'(MAX_KERNEL) :
                  KSW'(cfg_wdata_i[2:0]);
        end
        REG_IN_ZP:  izp_q <= cfg_wdata_i;
        REG_OUT_ZP: ozp_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ctl_q       <= '0;
      out_valid_o <= 1'b0;
      o_q         <= '0;
      m_q         <= '0;
      n_q         <= '0;
      i_q         <= '0;
      row_q       <= '0;
      col_q       <= '0;
      activation_o <= '0;
      last_o      <= 1'b0;
    end else begin
      ctl_q <= issue;
      case (state_q)
        ST_IDLE: begin
          if (in_acc && (action_i == ACT_COMPUTE) && in_map) begin
            row_q   <= row_i;
            col_q   <= col_i;
            o_q     <= '0;
            m_q     <= '0;
            n_q     <= '0;
            i_q     <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (last_i) begin
            i_q <= '0;
            if (last_n) begin
              n_q <= '0;
              m_q <= last_el ? '0 : m_q + 1'b1;
            end else begin
              n_q <= n_q + 1'b1;
            end
          end else begin
            i_q <= i_q + 1'b1;
          end
          if (last_el) begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (rq_valid) begin
            activation_o <= rq_act;
            last_o       <= (o_q == oc_q - 1'b1);
            out_valid_o  <= 1'b1;
            state_q      <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            if (last_o) begin
              state_q <= ST_IDLE;
            end else begin
              o_q     <= o_q + 1'b1;
              state_q <= ST_RUN;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_row_o  = row_q;
  assign out_col_o  = col_q;
  assign out_chan_o = 4'(o_q);

  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == ST_OUT)) else $error("result shown outside output state");
  a_rq_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_valid |-> (state_q == ST_WAIT)) else $error("requantize result while not waiting");
  a_last_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (o_q == oc_q - 1'b1)) else $error("last flag on wrong channel");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mac_done && !rq_valid) else $error("pipeline busy while idle");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o && !ctl_q.valid) else $error("input taken while busy");
endmodule
`default_nettype wire

// ----- tb/int8_conv2d_requantize_test.sv -----
// int8_conv2d_requantize_test: self-checking testbench for the int8 conv2d requantize block.
// Loads stores, computes positions under several register settings, and predicts each result.
// Depends on i8c_pkg and int8_conv2d_requantize.
module int8_conv2d_requantize_test;
  import i8c_pkg::*;

  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int IMG_SIDE = DEF_MAX_IMAGE;
  localparam int N_IC = DEF_MAX_IN_CHANNELS;
  localparam int N_OC = DEF_MAX_OUT_CHANNELS;
  localparam int N_K = DEF_MAX_KERNEL;

  typedef struct {
    logic [1:0]         act;
    logic [4:0]         row;
    logic [4:0]         col;
    logic [2:0]         ich;
    logic [3:0]         och;
    logic [2:0]         krow;
    logic [2:0]         kcol;
    logic signed [7:0]  smp;
    logic signed [15:0] bias;
    logic signed [31:0] mult;
    logic [4:0]         shft;
  } item_t;

  typedef struct {
    logic [4:0]        row;
    logic [4:0]        col;
    logic [3:0]        chan;
    logic signed [7:0] act;
    logic              last;
  } pixel_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_addr_i = '0;
  logic [7:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] action_i = '0;
  logic [4:0] row_i = '0;
  logic [4:0] col_i = '0;
  logic [2:0] in_channel_i = '0;
  logic [3:0] out_channel_i = '0;
  logic [2:0] kernel_row_i = '0;
  logic [2:0] kernel_col_i = '0;
  logic signed [7:0] sample_i = '0;
  logic signed [15:0] channel_bias_i = '0;
  logic signed [31:0] multiplier_i = '0;
  logic [4:0] right_shift_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [4:0] out_row_o;
  logic [4:0] out_col_o;
  logic [3:0] out_chan_o;
  logic signed [7:0] activation_o;
  logic last_o;

  int8_conv2d_requantize dut (.*);

  // predictor state
  int n_ic, n_oc, n_img, n_k, in_zp, out_zp;
  logic signed [7:0]  pix_mem [IMG_SIDE*IMG_SIDE*N_IC];
  logic signed [7:0]  wgt_mem [N_OC*N_K*N_K*N_IC];
  logic signed [15:0] bias_mem [N_OC];
  logic signed [31:0] mult_mem [N_OC];
  logic [4:0]         shift_mem [N_OC];

  // generator bookkeeping: which entries have been scheduled for loading
  bit pix_set [IMG_SIDE*IMG_SIDE*N_IC];
  bit wgt_set [N_OC*N_K*N_K*N_IC];
  bit par_set [N_OC];

  item_t pending[$];
  item_t cur_item;
  pixel_out_t expected_px[$];
  int send_gap, recv_stall, errors, n_items, n_results, n_computes;
  bit snd_burst, rcv_burst;

  initial forever #5 clk_i = ~clk_i;

  function automatic int clamp_reg(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int dbl_high(int a, int b);
    longint p, nud;
    if (a == 32'h8000_0000 && b == 32'h8000_0000) return 32'h7fff_ffff;
    p = longint'(a) * longint'(b);
    nud = (p >= 0) ? (64'sd1 <<< 30) : (64'sd1 - (64'sd1 <<< 30));
    return int'((p + nud) / (64'sd1 <<< 31));
  endfunction

  function automatic int round_shift(int x, int s);
    bit [31:0] ux, mask, rem, thr;
    longint q;
    ux = x;
    mask = 32'((64'd1 << s) - 64'd1);
    rem = ux & mask;
    thr = (mask >> 1) + ((x < 0) ? 32'd1 : 32'd0);
    q = longint'(x) >>> s;
    return int'(q + ((rem > thr) ? 1 : 0));
  endfunction

  function automatic int pix_idx(int r, int c, int i);
    return (r * IMG_SIDE + c) * N_IC + i;
  endfunction

  function automatic int wgt_idx(int o, int m, int n, int i);
    return ((o * N_K + m) * N_K + n) * N_IC + i;
  endfunction

  function automatic void apply_item(item_t it);
    bit [31:0] acc;
    int fm, hp, sh, v;
    pixel_out_t px;
    case (it.act)
      ACT_PIXEL: pix_mem[pix_idx(int'(it.row), int'(it.col), int'(it.ich))] = it.smp;
      ACT_WEIGHT:
        if (it.krow < N_K && it.kcol < N_K)
          wgt_mem[wgt_idx(int'(it.och), int'(it.krow), int'(it.kcol), int'(it.ich))] = it.smp;
      ACT_PARAM: begin
        bias_mem[it.och] = it.bias;
        mult_mem[it.och] = it.mult;
        shift_mem[it.och] = it.shft;
      end
      default: begin
        if (n_k > n_img) return;
        fm = n_img - n_k + 1;
        if (it.row >= fm || it.col >= fm) return;
        n_computes++;
        for (int o = 0; o < n_oc; o++) begin
          acc = '0;
          for (int m = 0; m < n_k; m++)
            for (int n = 0; n < n_k; n++)
              for (int i = 0; i < n_ic; i++)
                acc += 32'(int'(wgt_mem[wgt_idx(o, m, n, i)]) *
                       (int'(pix_mem[pix_idx(int'(it.row) + m, int'(it.col) + n, i)]) -
                        in_zp));
          acc += 32'(int'(bias_mem[o]));
          hp = dbl_high(int'(acc), mult_mem[o]);
          sh = round_shift(hp, int'(shift_mem[o]));
          v = sh + out_zp;
          if (v < -128) v = -128;
          if (v > 127) v = 127;
          px.row = it.row;
          px.col = it.col;
          px.chan = o[3:0];
          px.act = v[7:0];
          px.last = (o + 1 == n_oc);
          expected_px.push_back(px);
        end
      end
    endcase
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !in_ready_o)) begin
      if (in_valid_i) apply_item(cur_item);
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending.size() != 0) begin
        cur_item = pending.pop_front();
        action_i <= cur_item.act;
        row_i <= cur_item.row;
        col_i <= cur_item.col;
        in_channel_i <= cur_item.ich;
        out_channel_i <= cur_item.och;
        kernel_row_i <= cur_item.krow;
        kernel_col_i <= cur_item.kcol;
        sample_i <= cur_item.smp;
        channel_bias_i <= cur_item.bias;
        multiplier_i <= cur_item.mult;
        right_shift_i <= cur_item.shft;
        in_valid_i <= 1'b1;
        send_gap = snd_burst ? 0 : $urandom_range(0, 9);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_out_t px;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (expected_px.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result row %0d col %0d chan %0d act %0d",
                     out_row_o, out_col_o, out_chan_o, activation_o);
        end else begin
          px = expected_px.pop_front();
          if (px.row !== out_row_o || px.col !== out_col_o || px.chan !== out_chan_o ||
              px.act !== activation_o || px.last !== last_o) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp r%0d c%0d ch%0d act %0d last %0d, got r%0d c%0d ch%0d act %0d last %0d",
                       px.row, px.col, px.chan, px.act, px.last,
                       out_row_o, out_col_o, out_chan_o, activation_o, last_o);
          end
        end
        recv_stall = rcv_burst ? 0 : $urandom_range(0, 9);
      end
      if (recv_stall != 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic item_t rand_item();
    item_t it;
    it.act = 2'($urandom);
    it.row = 5'($urandom);
    it.col = 5'($urandom);
    it.ich = 3'($urandom);
    it.och = 4'($urandom);
    it.krow = 3'($urandom);
    it.kcol = 3'($urandom);
    it.smp = 8'($urandom);
    it.bias = 16'($urandom);
    it.mult = $urandom;
    it.shft = 5'($urandom);
    return it;
  endfunction

  function automatic logic signed [7:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return -8'sd128;
      1: return 8'sd127;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void push_pixel(int r, int c, int i);
    item_t it;
    it = rand_item();
    it.act = ACT_PIXEL;
    it.row = 5'(r);
    it.col = 5'(c);
    it.ich = 3'(i);
    it.smp = rand_sample();
    pix_set[pix_idx(r, c, i)] = 1'b1;
    pending.push_back(it);
    n_items++;
  endfunction

  function automatic void push_weight(int o, int m, int n, int i);
    item_t it;
    it = rand_item();
    it.act = ACT_WEIGHT;
    it.och = 4'(o);
    it.krow = 3'(m);
    it.kcol = 3'(n);
    it.ich = 3'(i);
    it.smp = rand_sample();
    if (m < N_K && n < N_K) begin
      wgt_set[wgt_idx(o, m, n, i)] = 1'b1;
    end
    pending.push_back(it);
    n_items++;
  endfunction

  function automatic void push_param(int o, logic signed [31:0] mult, int shft);
    item_t it;
    it = rand_item();
    it.act = ACT_PARAM;
    it.och = 4'(o);
    it.mult = mult;
    it.shft = 5'(shft);
    if ($urandom_range(0, 5) == 0) it.bias = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    par_set[o] = 1'b1;
    pending.push_back(it);
    n_items++;
  endfunction

  function automatic void push_rand_param(int o);
    logic signed [31:0] mult;
    case ($urandom_range(0, 7))
      0: mult = 32'sh8000_0000;
      1: mult = 32'sh7fff_ffff;
      default: mult = $urandom;
    endcase
    push_param(o, mult, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(0, 8));
  endfunction

  function automatic void push_compute(int r, int c);
    item_t it;
    it = rand_item();
    it.act = ACT_COMPUTE;
    it.row = 5'(r);
    it.col = 5'(c);
    pending.push_back(it);
    n_items++;
  endfunction

  // loads every entry the window at (r, c) reads that was never scheduled, then computes
  function automatic void compute_at(int r, int c);
    int fm;
    fm = n_img - n_k + 1;
    if (n_k <= n_img && r < fm && c < fm) begin
      for (int o = 0; o < n_oc; o++) begin
        if (!par_set[o]) push_rand_param(o);
        for (int m = 0; m < n_k; m++)
          for (int n = 0; n < n_k; n++)
            for (int i = 0; i < n_ic; i++)
              if (!wgt_set[wgt_idx(o, m, n, i)]) push_weight(o, m, n, i);
      end
      for (int m = 0; m < n_k; m++)
        for (int n = 0; n < n_k; n++)
          for (int i = 0; i < n_ic; i++)
            if (!pix_set[pix_idx(r + m, c + n, i)]) push_pixel(r + m, c + n, i);
    end
    push_compute(r, c);
  endfunction

  task automatic set_reg(logic [2:0] idx, int val);
    logic [7:0] d;
    d = 8'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= d;
    case (idx)
      REG_IN_CH:  n_ic = clamp_reg(int'(d & 8'h0f), N_IC);
      REG_OUT_CH: n_oc = clamp_reg(int'(d & 8'h1f), N_OC);
      REG_IMAGE:  n_img = clamp_reg(int'(d & 8'h3f), IMG_SIDE);
      REG_KERNEL: n_k = clamp_reg(int'(d & 8'h07), N_K);
      REG_IN_ZP:  in_zp = int'(signed'(d));
      REG_OUT_ZP: out_zp = int'(signed'(d));
      default: ;
    endcase
  endtask

  task automatic configure(int ic, int oc, int img, int k, int izp, int ozp);
    set_reg(REG_IN_CH, ic);
    set_reg(REG_OUT_CH, oc);
    set_reg(REG_IMAGE, img);
    set_reg(REG_KERNEL, k);
    set_reg(REG_IN_ZP, izp);
    set_reg(REG_OUT_ZP, ozp);
    set_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    snd_burst = ($urandom_range(0, 3) == 0);
    rcv_burst = ($urandom_range(0, 3) == 0);
  endtask

  task automatic drain();
    while (pending.size() != 0 || in_valid_i || expected_px.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    int fm, r, c, n_phases;
    n_ic = 1; n_oc = 1; n_img = 32; n_k = 5; in_zp = 0; out_zp = 0;
    foreach (pix_mem[j]) pix_mem[j] = '0;
    foreach (wgt_mem[j]) wgt_mem[j] = '0;
    foreach (bias_mem[j]) begin
      bias_mem[j] = '0; mult_mem[j] = '0; shift_mem[j] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // small map, extreme zero points and multipliers, out-of-map and ignored loads
    configure(2, 3, 4, 2, -128, 127);
    push_param(0, 32'sh8000_0000, 0);
    push_param(1, 32'sh7fff_ffff, 31);
    push_param(2, 32'sh4000_0000, 1);
    push_weight(1, 7, 0, 0);
    push_weight(2, 0, 5, 1);
    compute_at(0, 0);
    compute_at(2, 2);
    push_compute(3, 0);
    push_compute(31, 31);
    drain();

    // kernel wider than the image: no results
    configure(1, 1, 3, 5, 127, -128);
    push_compute(0, 0);
    drain();

    // every size register at its top, raw values saturating; positions past the map
    configure(15, 31, 63, 7, 127, -128);
    push_compute(28, 0);
    push_compute(0, 31);
    drain();

    // every size register at its floor
    configure(0, 0, 0, 0, -128, 127);
    compute_at(0, 0);
    push_compute(0, 1);
    drain();

    n_phases = 0;
    while (n_items < 160) begin
      configure($urandom_range(1, 2), $urandom_range(1, 3), $urandom_range(2, 10),
                $urandom_range(1, 2), $urandom, $urandom);
      fm = n_img - n_k + 1;
      repeat ($urandom_range(2, 4)) begin
        repeat ($urandom_range(0, 2)) begin
          case ($urandom_range(0, 2))
            0: push_pixel($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 7));
            1: push_weight($urandom_range(0, 15), $urandom_range(5, 7), $urandom_range(0, 7),
                           $urandom_range(0, 7));
            default: push_rand_param($urandom_range(0, 15));
          endcase
        end
        if (fm < 1 || fm > 31 || $urandom_range(0, 5) == 0) begin
          r = $urandom_range(fm < 1 ? 0 : fm, 31);
          c = $urandom_range(0, 31);
        end else begin
          r = $urandom_range(0, fm - 1);
          c = $urandom_range(0, fm - 1);
        end
        compute_at(r, c);
      end
      drain();
      n_phases++;
    end

    $display("Covered %0d loads and computes over %0d random settings plus directed cases;",
             n_items, n_phases);
    $display("%0d positions computed, %0d results checked, %0d errors.",
             n_computes, n_results, errors);
    if (errors == 0 && expected_px.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", expected_px.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
